// File: design/msrlm_pkg.sv
package msrlm_pkg;

    localparam int LANES = 4;
    localparam int LEN_W = 31;
    localparam int VAL_W = 16;
    localparam int NORM_W = 24;
    localparam logic [NORM_W-1:0] NORM_MAX = 24'hFF_FFFF;

    // Configuration register indexes
    localparam logic [2:0] CFG_FACTOR0 = 3'd0;
    localparam logic [2:0] CFG_FACTOR1 = 3'd1;
    localparam logic [2:0] CFG_FACTOR2 = 3'd2;
    localparam logic [2:0] CFG_FACTOR3 = 3'd3;
    localparam logic [2:0] CFG_CHROM_COUNT = 3'd4;

    typedef struct packed {
        logic [1:0]       sample;
        logic [LEN_W-1:0] run_length;
        logic [VAL_W-1:0] run_value;
        logic             stream_done;
    } in_t;

    typedef struct packed {
        logic [31:0]       start_position;
        logic [LEN_W-1:0]  segment_length;
        logic [15:0]       chromosome_index;
        logic              new_chromosome;
        logic [VAL_W-1:0]  raw0;
        logic [VAL_W-1:0]  raw1;
        logic [VAL_W-1:0]  raw2;
        logic [VAL_W-1:0]  raw3;
        logic [NORM_W-1:0] norm0;
        logic [NORM_W-1:0] norm1;
        logic [NORM_W-1:0] norm2;
        logic [NORM_W-1:0] norm3;
    } out_t;

    // Running summary handed from cell to cell
    typedef struct packed {
        logic             loaded;   // some cell took a run this cycle
        logic             waiting;  // some cell still needs a run
        logic             live;     // some cell not finished
        logic [LEN_W-1:0] min_len;  // shortest remaining run among live cells
    } chain_t;

    // raw * Q8.8 factor, round half up, saturate
    function automatic logic [NORM_W-1:0] normalize(input logic [VAL_W-1:0] raw,
                                                    input logic [15:0] factor);
        logic [31:0] prod;
        logic [32:0] sum;
        logic [24:0] shifted;
        prod = 32'(raw) * 32'(factor);
        sum = {1'b0, prod} + 33'd128;
        shifted = sum[32:8];
        if (shifted > 25'(NORM_MAX))
        begin
            return NORM_MAX;
        end
        return shifted[NORM_W-1:0];
    endfunction

endpackage

// File: design/msrlm_cell.sv
// One sample lane: holds its current run and joins the min chain.
module msrlm_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          pick,
    input  msrlm_pkg::in_t                item,
    input  logic                          fire,
    input  logic                          clear,
    input  logic [msrlm_pkg::LEN_W-1:0]   step,
    input  msrlm_pkg::chain_t             chain_in,
    output msrlm_pkg::chain_t             chain_out,
    output logic [msrlm_pkg::VAL_W-1:0]   raw
);

    logic [msrlm_pkg::LEN_W-1:0] rem_reg, rem_next, rem_post;
    logic [msrlm_pkg::VAL_W-1:0] value_reg, value_next, value_post;
    logic finished_reg, finished_next, finished_post;
    logic awaiting_reg, awaiting_next, awaiting_post;
    logic load;

    // zero-length runs are dropped; sample keeps waiting
    assign load = pick && awaiting_reg &&
                  (item.stream_done || (item.run_length != '0));

    always_comb
    begin
        rem_post      = rem_reg;
        value_post    = value_reg;
        finished_post = finished_reg;
        awaiting_post = awaiting_reg;
        if (load)
        begin
            awaiting_post = 1'b0;
            if (item.stream_done)
            begin
                finished_post = 1'b1;
                rem_post      = '0;
                value_post    = '0;
            end
            else
            begin
                rem_post   = item.run_length;
                value_post = item.run_value;
            end
        end
    end

    always_comb
    begin
        chain_out.loaded  = chain_in.loaded | load;
        chain_out.waiting = chain_in.waiting | awaiting_post;
        chain_out.live    = chain_in.live | ~finished_post;
        chain_out.min_len = chain_in.min_len;
        if (!finished_post && (!chain_in.live || rem_post < chain_in.min_len))
        begin
            chain_out.min_len = rem_post;
        end
    end

    assign raw = value_post;

    always_comb
    begin
        rem_next      = rem_post;
        value_next    = value_post;
        finished_next = finished_post;
        awaiting_next = awaiting_post;
        priority if (clear)
        begin
            rem_next      = '0;
            value_next    = '0;
            finished_next = 1'b0;
            awaiting_next = 1'b1;
        end
        else if (fire && !finished_post)
        begin
            rem_next      = rem_post - step;
            awaiting_next = (rem_post == step);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg      <= '0;
            value_reg    <= '0;
            finished_reg <= 1'b0;
            awaiting_reg <= 1'b1;
        end
        else
        begin
            rem_reg      <= rem_next;
            value_reg    <= value_next;
            finished_reg <= finished_next;
            awaiting_reg <= awaiting_next;
        end
    end

endmodule

// File: design/multi_stream_run_length_merger.sv
// Merges SAMPLES run-length coded coverage streams into common segments. Each
// input transfer carries the next run (length, value) of one sample, or marks
// that sample done for the current chromosome. Once no sample waits for a run,
// one segment goes out: it spans the shortest remaining run, carries every raw
// value and its Q8.8-normalized value (rounded half up, saturated to 24 bits),
// and the runs are shortened by that step. When every sample is done the
// chromosome index advances, position restarts at 0 and the next segment is
// flagged new_chromosome. After chromosome_count chromosomes all inputs are
// dropped. Rate: one input transfer per clock while the output is not stalled;
// a segment is registered in the segment stage, then in the output register.
// The cycle time is set by the cell chain: load of the run, the four-cell min
// compare and the subtract of the step, all in one combinational path.
// Registers 0..3 hold the per-sample factors (reset 1.0), register 4 the
// chromosome count (reset 1); write them only while the block is idle.
module multi_stream_run_length_merger #(
    parameter int SAMPLES = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  msrlm_pkg::in_t    in_item,
    output logic              out_valid,
    input  logic              out_ready,
    output msrlm_pkg::out_t   out_item,
    input  logic              cfg_write,
    input  logic [2:0]        cfg_index,
    input  logic [15:0]       cfg_data
);

    localparam int LW = msrlm_pkg::LEN_W;
    localparam int VW = msrlm_pkg::VAL_W;

    // configuration
    logic [15:0] factor_reg [msrlm_pkg::LANES];
    logic [15:0] count_reg;

    // chromosome and position state
    logic [31:0] pos_reg, pos_next;
    logic [15:0] chrom_reg, chrom_next;
    logic        pending_reg, pending_next;

    // cell chain
    msrlm_pkg::chain_t chain [SAMPLES+1];
    logic [VW-1:0]     lane_raw [msrlm_pkg::LANES];
    logic              go, emit, advance;
    logic [LW-1:0]     step;

    // segment stage (before the multiply) and output register
    logic            s1_valid_reg, s1_valid_next;
    logic [31:0]     s1_pos_reg;
    logic [LW-1:0]   s1_len_reg;
    logic [15:0]     s1_chrom_reg;
    logic            s1_new_reg;
    logic [VW-1:0]   s1_raw_reg [msrlm_pkg::LANES];
    logic            out_valid_reg, out_valid_next;
    msrlm_pkg::out_t out_item_reg;
    logic            s1_adv;

    // Ready reaches back through both stages so a full pipe still streams.
    assign s1_adv   = !out_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || s1_adv;

    // Transfers after the last chromosome are dropped.
    assign go = in_valid && in_ready && (chrom_reg < count_reg);

    assign chain[0] = '0;

    for (genvar i = 0; i < msrlm_pkg::LANES; i++)
    begin : g_lane
        if (i < SAMPLES)
        begin : g_cell
            msrlm_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .pick      (go && (in_item.sample == 2'(i))),
                .item      (in_item),
                .fire      (emit),
                .clear     (advance),
                .step      (step),
                .chain_in  (chain[i]),
                .chain_out (chain[i+1]),
                .raw       (lane_raw[i])
            );
        end
        else
        begin : g_absent
            assign lane_raw[i] = '0;
        end
    end

    // Emit once every sample holds a run; if none is live, move to the
    // next chromosome instead.
    assign step    = chain[SAMPLES].min_len;
    assign emit    = go && chain[SAMPLES].loaded && !chain[SAMPLES].waiting &&
                     chain[SAMPLES].live;
    assign advance = go && chain[SAMPLES].loaded && !chain[SAMPLES].waiting &&
                     !chain[SAMPLES].live;

    always_comb
    begin
        pos_next     = pos_reg;
        chrom_next   = chrom_reg;
        pending_next = pending_reg;
        priority if (advance)
        begin
            chrom_next   = chrom_reg + 16'd1;
            pos_next     = '0;
            pending_next = 1'b1;
        end
        else if (emit)
        begin
            pos_next     = pos_reg + 32'(step);
            pending_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            chrom_reg   <= '0;
            pending_reg <= 1'b0;
        end
        else
        begin
            pos_reg     <= pos_next;
            chrom_reg   <= chrom_next;
            pending_reg <= pending_next;
        end
    end

    // configuration writes; unknown indexes are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < msrlm_pkg::LANES; k++)
            begin
                factor_reg[k] <= 16'd256;
            end
            count_reg <= 16'd1;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                msrlm_pkg::CFG_FACTOR0:     factor_reg[0] <= cfg_data;
                msrlm_pkg::CFG_FACTOR1:     factor_reg[1] <= cfg_data;
                msrlm_pkg::CFG_FACTOR2:     factor_reg[2] <= cfg_data;
                msrlm_pkg::CFG_FACTOR3:     factor_reg[3] <= cfg_data;
                msrlm_pkg::CFG_CHROM_COUNT: count_reg     <= cfg_data;
                default:                    ;
            endcase
        end
    end

    // valid bits of the two result stages
    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;
        if (s1_adv)
        begin
            out_valid_next = s1_valid_reg;
        end
        if (in_ready)
        begin
            s1_valid_next = emit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_ready && emit)
        begin
            s1_pos_reg   <= pos_reg;
            s1_len_reg   <= step;
            s1_chrom_reg <= chrom_reg;
            s1_new_reg   <= pending_reg;
            for (int k = 0; k < msrlm_pkg::LANES; k++)
            begin
                s1_raw_reg[k] <= lane_raw[k];
            end
        end
        if (s1_adv && s1_valid_reg)
        begin
            out_item_reg.start_position   <= s1_pos_reg;
            out_item_reg.segment_length   <= s1_len_reg;
            out_item_reg.chromosome_index <= s1_chrom_reg;
            out_item_reg.new_chromosome   <= s1_new_reg;
            out_item_reg.raw0  <= s1_raw_reg[0];
            out_item_reg.raw1  <= s1_raw_reg[1];
            out_item_reg.raw2  <= s1_raw_reg[2];
            out_item_reg.raw3  <= s1_raw_reg[3];
            out_item_reg.norm0 <= msrlm_pkg::normalize(s1_raw_reg[0], factor_reg[0]);
            out_item_reg.norm1 <= msrlm_pkg::normalize(s1_raw_reg[1], factor_reg[1]);
            out_item_reg.norm2 <= msrlm_pkg::normalize(s1_raw_reg[2], factor_reg[2]);
            out_item_reg.norm3 <= msrlm_pkg::normalize(s1_raw_reg[3], factor_reg[3]);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

// File: design/msrlm_checker.sv
module msrlm_sva (
    input logic            clk,
    input logic            rst_n,
    input logic            out_valid,
    input logic            out_ready,
    input msrlm_pkg::out_t out_item
);

    logic out_xfer;
    assign out_xfer = out_valid && out_ready;

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
        else $error("result changed while stalled");

    // back-to-back segments of one chromosome tile the positions
    a_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        out_xfer && $past(out_xfer) && !out_item.new_chromosome |->
            out_item.start_position ==
            $past(out_item.start_position) + 32'($past(out_item.segment_length)))
        else $error("segment gap or overlap");

    // a new chromosome starts at position zero
    a_new_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.new_chromosome |-> out_item.start_position == '0)
        else $error("new chromosome not at zero");

    a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_item.segment_length != '0)
        else $error("empty segment");

    a_zero_norm: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.raw0 == '0 |-> out_item.norm0 == '0)
        else $error("zero coverage normalized to nonzero");

endmodule

bind multi_stream_run_length_merger msrlm_sva u_msrlm_checker (.*);
